// ===== rtl/core/qtm_pkg.sv =====
package qtm_pkg;

    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [11:0] PULSE_MIN = 12'd1000;
    localparam logic [11:0] PULSE_MAX = 12'd2000;
    localparam logic [11:0] PULSE_MID = 12'd1500;
    localparam logic [16:0] RECIP_125 = 17'd67109;
    localparam int unsigned RECIP_SHIFT = 23;
    localparam int unsigned DIV_STAGES = 16;

    localparam logic [1:0] REG_MAX_BOOST = 2'd0;
    localparam logic [1:0] REG_MAX_THR = 2'd1;
    localparam logic [1:0] REG_DIFF_THRUST = 2'd2;

    typedef struct packed {
        logic signed [15:0] roll_demand;
        logic signed [15:0] roll_feedforward;
        logic signed [15:0] pitch_demand;
        logic signed [15:0] pitch_feedforward;
        logic signed [15:0] yaw_demand;
        logic signed [15:0] yaw_feedforward;
        logic [14:0]        throttle_demand;
        logic [14:0]        comp_gain;
        logic [14:0]        ext_min_throttle;
        logic [11:0]        pitch_stick_pulse;
        logic [11:0]        yaw_stick_pulse;
    } qtm_in_t;

    typedef struct packed {
        logic [14:0]        thrust_front_a;
        logic [14:0]        thrust_front_b;
        logic [14:0]        thrust_rear_a;
        logic [14:0]        thrust_rear_b;
        logic signed [15:0] avg_throttle_out;
        logic signed [15:0] tilt_pitch_cmd;
        logic signed [15:0] tilt_yaw_cmd;
        logic               hit_throttle_low;
        logic               hit_throttle_high;
        logic               hit_roll_limit;
    } qtm_out_t;

    typedef struct packed {
        logic [14:0] boost_limit;
        logic [14:0] max_throttle;
        logic        diff_thrust_present;
    } qtm_cfg_t;

    typedef struct packed {
        logic signed [18:0] roll;
        logic signed [16:0] pitch;
        logic signed [16:0] yaw;
        logic [16:0]        thr;
        logic [16:0]        boost;
        logic signed [15:0] wp;
        logic signed [15:0] wy;
        logic [14:0]        s;
        logic [14:0]        m;
        logic [14:0]        g;
        logic               lo;
        logic               hi;
        logic               rl;
    } qtm_f2m_t;

    typedef struct packed {
        logic [14:0]        t0;
        logic [14:0]        t1;
        logic [14:0]        t2;
        logic [14:0]        t3;
        logic signed [15:0] tilt_pitch;
        logic signed [15:0] tilt_yaw;
        logic               lo;
        logic               hi;
        logic               rl;
    } qtm_side_t;

    typedef struct packed {
        qtm_side_t   side;
        logic [15:0] rem;
        logic [15:0] low;
        logic [15:0] divisor;
        logic        ovf;
        logic        neg;
    } qtm_m2d_t;

endpackage

// ===== rtl/core/qtm_front.sv =====
module qtm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  qtm_pkg::qtm_in_t  in_data,
    input  qtm_pkg::qtm_cfg_t cfg,
    output logic              out_valid,
    output qtm_pkg::qtm_f2m_t out_data
);

    // stage 1
    logic               v1_reg;
    logic [14:0]        g1_reg;
    logic signed [16:0] roll1_reg, pitch1_reg, yaw1_reg;
    logic [14:0]        td1_reg, emin1_reg;
    logic [15:0]        xp1_reg, xy1_reg;
    logic [8:0]         adp1_reg, ady1_reg;
    logic               np1_reg, ny1_reg;

    logic [14:0] g1_next;
    logic [11:0] pp, py;
    logic        np1_next, ny1_next;
    logic [11:0] dp_abs, dy_abs;

    always_comb begin
        g1_next = (in_data.comp_gain < qtm_pkg::ONE_Q14) ? qtm_pkg::ONE_Q14 : in_data.comp_gain;
        if (in_data.pitch_stick_pulse < qtm_pkg::PULSE_MIN) begin
            pp = qtm_pkg::PULSE_MIN;
        end else if (in_data.pitch_stick_pulse > qtm_pkg::PULSE_MAX) begin
            pp = qtm_pkg::PULSE_MAX;
        end else begin
            pp = in_data.pitch_stick_pulse;
        end
        if (in_data.yaw_stick_pulse < qtm_pkg::PULSE_MIN) begin
            py = qtm_pkg::PULSE_MIN;
        end else if (in_data.yaw_stick_pulse > qtm_pkg::PULSE_MAX) begin
            py = qtm_pkg::PULSE_MAX;
        end else begin
            py = in_data.yaw_stick_pulse;
        end
        np1_next = pp < qtm_pkg::PULSE_MID;
        ny1_next = py < qtm_pkg::PULSE_MID;
        dp_abs = np1_next ? (qtm_pkg::PULSE_MID - pp) : (pp - qtm_pkg::PULSE_MID);
        dy_abs = ny1_next ? (qtm_pkg::PULSE_MID - py) : (py - qtm_pkg::PULSE_MID);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            g1_reg     <= g1_next;
            roll1_reg  <= $signed({in_data.roll_demand[15], in_data.roll_demand})
                        + $signed({in_data.roll_feedforward[15], in_data.roll_feedforward});
            pitch1_reg <= $signed({in_data.pitch_demand[15], in_data.pitch_demand})
                        + $signed({in_data.pitch_feedforward[15], in_data.pitch_feedforward});
            yaw1_reg   <= $signed({in_data.yaw_demand[15], in_data.yaw_demand})
                        + $signed({in_data.yaw_feedforward[15], in_data.yaw_feedforward});
            td1_reg    <= in_data.throttle_demand;
            emin1_reg  <= in_data.ext_min_throttle;
            adp1_reg   <= dp_abs[8:0];
            ady1_reg   <= dy_abs[8:0];
            xp1_reg    <= 16'(dp_abs) * 16'd96 + 16'd62;
            xy1_reg    <= 16'(dy_abs) * 16'd96 + 16'd62;
            np1_reg    <= np1_next;
            ny1_reg    <= ny1_next;
        end
    end

    // stage 2: products
    logic               v2_reg;
    logic [14:0]        g2_reg, emin2_reg;
    logic signed [32:0] rollp2_reg;
    logic signed [16:0] pitch2_reg, yaw2_reg;
    logic [30:0]        thrp2_reg, boostp2_reg, maxp2_reg;
    logic [32:0]        qp2_reg, qy2_reg;
    logic [8:0]         adp2_reg, ady2_reg;
    logic               np2_reg, ny2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            g2_reg      <= g1_reg;
            emin2_reg   <= emin1_reg;
            rollp2_reg  <= $signed(roll1_reg) * $signed({1'b0, g1_reg});
            pitch2_reg  <= pitch1_reg;
            yaw2_reg    <= yaw1_reg;
            thrp2_reg   <= 31'(td1_reg) * 31'(g1_reg);
            boostp2_reg <= 31'(cfg.boost_limit) * 31'(g1_reg);
            maxp2_reg   <= 31'(cfg.max_throttle) * 31'(g1_reg);
            qp2_reg     <= 33'(xp1_reg) * 33'(qtm_pkg::RECIP_125);
            qy2_reg     <= 33'(xy1_reg) * 33'(qtm_pkg::RECIP_125);
            adp2_reg    <= adp1_reg;
            ady2_reg    <= ady1_reg;
            np2_reg     <= np1_reg;
            ny2_reg     <= ny1_reg;
        end
    end

    // stage 3: rounding, clamps, stick weights
    logic               v3_reg;
    qtm_pkg::qtm_f2m_t  f3_reg;
    qtm_pkg::qtm_f2m_t  f3_next;
    logic signed [18:0] roll_r;
    logic [16:0]        thr_r, thr_a, boost_r, maxo_r, min_out;
    logic [14:0]        wpm, wym;

    always_comb begin
        roll_r  = 19'((rollp2_reg + 33'sd8192) >>> 14);
        thr_r   = 17'((thrp2_reg + 31'd8192) >> 14);
        boost_r = 17'((boostp2_reg + 31'd8192) >> 14);
        maxo_r  = 17'((maxp2_reg + 31'd8192) >> 14);
        min_out = ({2'b00, emin2_reg} < boost_r) ? {2'b00, emin2_reg} : boost_r;
        wpm = 15'({adp2_reg, 5'b00000}) + 15'(qp2_reg >> qtm_pkg::RECIP_SHIFT);
        wym = 15'({ady2_reg, 5'b00000}) + 15'(qy2_reg >> qtm_pkg::RECIP_SHIFT);

        f3_next = '0;
        f3_next.lo = thr_r <= min_out;
        thr_a = f3_next.lo ? min_out : thr_r;
        f3_next.hi = thr_a >= maxo_r;
        f3_next.thr = f3_next.hi ? maxo_r : thr_a;
        f3_next.rl = roll_r >= 19'sd16384;
        f3_next.roll = f3_next.rl ? 19'sd16384 : roll_r;
        f3_next.pitch = pitch2_reg;
        f3_next.yaw = yaw2_reg;
        f3_next.boost = boost_r;
        f3_next.wp = np2_reg ? -$signed({1'b0, wpm}) : $signed({1'b0, wpm});
        f3_next.wy = ny2_reg ? -$signed({1'b0, wym}) : $signed({1'b0, wym});
        f3_next.s = wpm;
        f3_next.m = qtm_pkg::ONE_Q14 - wpm;
        f3_next.g = g2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            f3_reg <= f3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = f3_reg;

endmodule

// ===== rtl/core/qtm_mix.sv =====
module qtm_mix (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  qtm_pkg::qtm_f2m_t in_data,
    input  qtm_pkg::qtm_cfg_t cfg,
    output logic              out_valid,
    output qtm_pkg::qtm_m2d_t out_data
);

    // stage 4: first products
    logic               v4_reg;
    logic signed [32:0] r4_reg, p14_reg, s14_reg;
    logic signed [30:0] y4_reg;
    logic signed [29:0] wp4_reg, wy4_reg;
    logic [16:0]        thr4_reg, boost4_reg;
    logic [14:0]        g4_reg;
    logic [2:0]         fl4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
        end
        if (en) begin
            r4_reg     <= $signed(in_data.roll) * 33'sd7373;
            y4_reg     <= $signed(in_data.yaw) * 31'sd7373;
            p14_reg    <= $signed({1'b0, in_data.m}) * $signed(in_data.pitch);
            s14_reg    <= $signed({1'b0, in_data.s}) * $signed(in_data.pitch);
            wp4_reg    <= $signed(in_data.wp) * 30'sd11469;
            wy4_reg    <= $signed(in_data.wy) * 30'sd9830;
            thr4_reg   <= in_data.thr;
            boost4_reg <= in_data.boost;
            g4_reg     <= in_data.g;
            fl4_reg    <= {in_data.lo, in_data.hi, in_data.rl};
        end
    end

    // stage 5: second products
    logic               v5_reg;
    logic signed [32:0] r5_reg;
    logic signed [30:0] y5_reg;
    logic signed [46:0] p5_reg, ts5_reg;
    logic signed [29:0] wp5_reg, wy5_reg;
    logic [16:0]        thr5_reg, boost5_reg;
    logic [14:0]        g5_reg;
    logic [2:0]         fl5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            r5_reg     <= r4_reg;
            y5_reg     <= y4_reg;
            p5_reg     <= $signed(p14_reg) * 47'sd6554;
            ts5_reg    <= $signed(s14_reg) * 47'sd4915;
            wp5_reg    <= wp4_reg;
            wy5_reg    <= wy4_reg;
            thr5_reg   <= thr4_reg;
            boost5_reg <= boost4_reg;
            g5_reg     <= g4_reg;
            fl5_reg    <= fl4_reg;
        end
    end

    // stage 6: thrust sums and tilt commands
    logic signed [49:0] base6, rr6, yy6, pp6;
    logic signed [47:0] tp_sum;
    logic signed [19:0] tp_r;
    logic signed [15:0] tp_sat, ty_r;
    logic signed [21:0] t6_next [4];

    always_comb begin
        base6 = $signed({5'b00000, thr5_reg, 28'd0});
        rr6   = $signed({{3{r5_reg[32]}}, r5_reg, 14'd0});
        yy6   = $signed({{5{y5_reg[30]}}, y5_reg, 14'd0});
        pp6   = $signed({{3{p5_reg[46]}}, p5_reg});
        t6_next[0] = 22'((base6 - rr6 + pp6 + yy6 + 50'sd134217728) >>> 28);
        t6_next[1] = 22'((base6 + rr6 - pp6 + yy6 + 50'sd134217728) >>> 28);
        t6_next[2] = 22'((base6 + rr6 + pp6 - yy6 + 50'sd134217728) >>> 28);
        t6_next[3] = 22'((base6 - rr6 - pp6 - yy6 + 50'sd134217728) >>> 28);
        tp_sum = -$signed({{4{wp5_reg[29]}}, wp5_reg, 14'd0})
               - $signed({ts5_reg[46], ts5_reg}) + 48'sd134217728;
        tp_r = 20'(tp_sum >>> 28);
        if (tp_r > 20'sd32767) begin
            tp_sat = 16'sh7fff;
        end else if (tp_r < -20'sd32768) begin
            tp_sat = -16'sd32768;
        end else begin
            tp_sat = 16'(tp_r);
        end
        ty_r = 16'((wy5_reg + 30'sd8192) >>> 14);
    end

    logic               v6_reg;
    logic signed [21:0] t6_reg [4];
    logic signed [15:0] tp6_reg, ty6_reg;
    logic [16:0]        thr6_reg, boost6_reg;
    logic [14:0]        g6_reg;
    logic [2:0]         fl6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                t6_reg[k] <= t6_next[k];
            end
            tp6_reg    <= tp_sat;
            ty6_reg    <= ty_r;
            thr6_reg   <= thr5_reg;
            boost6_reg <= boost5_reg;
            g6_reg     <= g5_reg;
            fl6_reg    <= fl5_reg;
        end
    end

    // stage 7: max and min over all thrusts
    logic signed [21:0] tmax7, tmin7;

    always_comb begin
        tmax7 = t6_reg[0];
        tmin7 = t6_reg[0];
        for (int k = 1; k < 4; k++) begin
            if (t6_reg[k] > tmax7) begin
                tmax7 = t6_reg[k];
            end
            if (t6_reg[k] < tmin7) begin
                tmin7 = t6_reg[k];
            end
        end
    end

    logic               v7_reg;
    logic signed [21:0] t7_reg [4];
    logic signed [21:0] tmax7_reg, tmin7_reg;
    logic signed [15:0] tp7_reg, ty7_reg;
    logic [16:0]        thr7_reg, boost7_reg;
    logic [14:0]        g7_reg;
    logic [2:0]         fl7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                t7_reg[k] <= t6_reg[k];
            end
            tmax7_reg  <= tmax7;
            tmin7_reg  <= tmin7;
            tp7_reg    <= tp6_reg;
            ty7_reg    <= ty6_reg;
            thr7_reg   <= thr6_reg;
            boost7_reg <= boost6_reg;
            g7_reg     <= g6_reg;
            fl7_reg    <= fl6_reg;
        end
    end

    // stage 8: headroom adjustment
    logic signed [23:0] thr8s, boost8s, adj8;
    logic               lo8, hi8, rl8;

    always_comb begin
        thr8s   = $signed({7'd0, thr7_reg});
        boost8s = $signed({7'd0, boost7_reg});
        adj8 = '0;
        lo8 = fl7_reg[2];
        hi8 = fl7_reg[1];
        rl8 = fl7_reg[0];
        if (tmax7_reg > 22'sd16384) begin
            adj8 = 24'sd16384 - $signed({{2{tmax7_reg[21]}}, tmax7_reg});
            hi8 = 1'b1;
        end else if (tmin7_reg < 22'sd0) begin
            adj8 = -$signed({{2{tmin7_reg[21]}}, tmin7_reg});
            if (thr8s + adj8 > boost8s) begin
                adj8 = (boost8s > thr8s) ? (boost8s - thr8s) : 24'sd0;
                rl8 = 1'b1;
            end
            lo8 = 1'b1;
        end
    end

    logic               v8_reg;
    logic signed [21:0] t8_reg [4];
    logic signed [23:0] adj8_reg, thr8_reg;
    logic signed [15:0] tp8_reg, ty8_reg;
    logic [14:0]        g8_reg;
    logic [2:0]         fl8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= v7_reg;
        end
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                t8_reg[k] <= t7_reg[k];
            end
            adj8_reg <= adj8;
            thr8_reg <= thr8s;
            tp8_reg  <= tp7_reg;
            ty8_reg  <= ty7_reg;
            g8_reg   <= g7_reg;
            fl8_reg  <= {lo8, hi8, rl8};
        end
    end

    // stage 9: output clamps and divider setup
    logic signed [23:0] ta9 [4];
    logic [14:0]        tc9 [4];
    logic signed [23:0] n9;
    logic [23:0]        an9;
    logic [38:0]        dvd9;
    qtm_pkg::qtm_m2d_t  d9_next;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ta9[k] = $signed({{2{t8_reg[k][21]}}, t8_reg[k]}) + adj8_reg;
            if (ta9[k] < 24'sd0) begin
                tc9[k] = '0;
            end else if (ta9[k] > 24'sd16384) begin
                tc9[k] = qtm_pkg::ONE_Q14;
            end else begin
                tc9[k] = 15'(ta9[k]);
            end
        end
        n9   = cfg.diff_thrust_present ? (thr8_reg + adj8_reg) : thr8_reg;
        an9  = n9[23] ? 24'(-n9) : 24'(n9);
        dvd9 = {an9, g8_reg};

        d9_next = '0;
        d9_next.side.t0 = tc9[0];
        d9_next.side.t1 = tc9[1];
        d9_next.side.t2 = tc9[2];
        d9_next.side.t3 = tc9[3];
        d9_next.side.tilt_pitch = tp8_reg;
        d9_next.side.tilt_yaw = ty8_reg;
        d9_next.side.lo = fl8_reg[2];
        d9_next.side.hi = fl8_reg[1];
        d9_next.side.rl = fl8_reg[0];
        d9_next.rem = dvd9[31:16];
        d9_next.low = dvd9[15:0];
        d9_next.divisor = {g8_reg, 1'b0};
        d9_next.ovf = dvd9 >= 39'({g8_reg, 17'd0});
        d9_next.neg = n9[23];
    end

    logic              v9_reg;
    qtm_pkg::qtm_m2d_t d9_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0;
        end else if (en) begin
            v9_reg <= v8_reg;
        end
        if (en) begin
            d9_reg <= d9_next;
        end
    end

    assign out_valid = v9_reg;
    assign out_data  = d9_reg;

endmodule

// ===== rtl/core/qtm_div.sv =====
module qtm_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  qtm_pkg::qtm_m2d_t in_data,
    output logic              out_valid,
    output qtm_pkg::qtm_out_t out_data
);

    localparam int unsigned NS = qtm_pkg::DIV_STAGES;

    logic [NS-1:0]       v_reg;
    logic [15:0]         rem_reg [NS];
    logic [15:0]         low_reg [NS];
    logic [15:0]         quo_reg [NS];
    logic [15:0]         dv_reg [NS];
    logic                ovf_reg [NS];
    logic                neg_reg [NS];
    qtm_pkg::qtm_side_t  side_reg [NS];

    logic [15:0] rem_next [NS];
    logic [15:0] low_next [NS];
    logic [15:0] quo_next [NS];
    logic [16:0] trial [NS];

    // one quotient bit per stage, restoring
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                trial[k] = {in_data.rem, in_data.low[15]};
                low_next[k] = {in_data.low[14:0], 1'b0};
                quo_next[k] = '0;
            end else begin
                trial[k] = {rem_reg[k-1], low_reg[k-1][15]};
                low_next[k] = {low_reg[k-1][14:0], 1'b0};
                quo_next[k] = {quo_reg[k-1][14:0], 1'b0};
            end
            if (trial[k] >= {1'b0, (k == 0) ? in_data.divisor : dv_reg[k-1]}) begin
                rem_next[k] = 16'(trial[k] - {1'b0, (k == 0) ? in_data.divisor : dv_reg[k-1]});
                quo_next[k][0] = 1'b1;
            end else begin
                rem_next[k] = trial[k][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
        if (en) begin
            for (int k = 0; k < NS; k++) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                if (k == 0) begin
                    dv_reg[k]   <= in_data.divisor;
                    ovf_reg[k]  <= in_data.ovf;
                    neg_reg[k]  <= in_data.neg;
                    side_reg[k] <= in_data.side;
                end else begin
                    dv_reg[k]   <= dv_reg[k-1];
                    ovf_reg[k]  <= ovf_reg[k-1];
                    neg_reg[k]  <= neg_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    // saturate and restore sign
    logic [15:0]        mag;
    logic signed [15:0] avg;
    qtm_pkg::qtm_side_t sd;
    qtm_pkg::qtm_out_t  o_next;

    always_comb begin
        mag = quo_reg[NS-1];
        sd  = side_reg[NS-1];
        if (!neg_reg[NS-1]) begin
            avg = (ovf_reg[NS-1] || mag > 16'd32767) ? 16'sh7fff : $signed(mag);
        end else begin
            avg = (ovf_reg[NS-1] || mag > 16'd32768) ? -16'sd32768 : -$signed(mag);
        end
        o_next.thrust_front_a    = sd.t0;
        o_next.thrust_front_b    = sd.t1;
        o_next.thrust_rear_a     = sd.t2;
        o_next.thrust_rear_b     = sd.t3;
        o_next.avg_throttle_out  = avg;
        o_next.tilt_pitch_cmd    = sd.tilt_pitch;
        o_next.tilt_yaw_cmd      = sd.tilt_yaw;
        o_next.hit_throttle_low  = sd.lo;
        o_next.hit_throttle_high = sd.hi;
        o_next.hit_roll_limit    = sd.rl;
    end

    logic              ov_reg;
    qtm_pkg::qtm_out_t o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= v_reg[NS-1];
        end
        if (en) begin
            o_reg <= o_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = o_reg;

endmodule

// ===== rtl/core/quad_tilt_motor_mixer.sv =====
// pipeline: 26 register stages between an accepted input item and its result item
// throughput: one item per cycle while the output is not stalled, set by the fully
// pipelined datapath and the 16-stage restoring divider for the average throttle
// a stall at the output holds the whole pipeline in place
// reset: synchronous active-low aresetn clears all valid bits and loads register defaults
module quad_tilt_motor_mixer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qtm_pkg::qtm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output qtm_pkg::qtm_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [14:0]       cfg_data
);

    qtm_pkg::qtm_cfg_t cfg_reg;
    logic              en;
    logic              f_valid, x_valid;
    qtm_pkg::qtm_f2m_t f_data;
    qtm_pkg::qtm_m2d_t x_data;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.boost_limit         <= qtm_pkg::ONE_Q14;
            cfg_reg.max_throttle        <= qtm_pkg::ONE_Q14;
            cfg_reg.diff_thrust_present <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                qtm_pkg::REG_MAX_BOOST: begin
                    cfg_reg.boost_limit <= cfg_data;
                end
                qtm_pkg::REG_MAX_THR: begin
                    cfg_reg.max_throttle <= cfg_data;
                end
                qtm_pkg::REG_DIFF_THRUST: begin
                    cfg_reg.diff_thrust_present <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    qtm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    qtm_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .cfg       (cfg_reg),
        .out_valid (x_valid),
        .out_data  (x_data)
    );

    qtm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (x_valid),
        .in_data   (x_data),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    a_thrust_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.thrust_front_a <= 15'd16384) && (m_data.thrust_front_b <= 15'd16384)
            && (m_data.thrust_rear_a <= 15'd16384) && (m_data.thrust_rear_b <= 15'd16384))
        else $error("thrust above full scale");

    a_tilt_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.tilt_yaw_cmd <= 16'sd9830) && (m_data.tilt_yaw_cmd >= -16'sd9830))
        else $error("tilt yaw command out of range");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// ===== bench/quad_tilt_motor_mixer_tb.sv =====
module quad_tilt_motor_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS = 550;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        qtm_pkg::qtm_in_t  din;
        logic              has_exp;
        qtm_pkg::qtm_out_t exp_out;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    qtm_pkg::qtm_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    qtm_pkg::qtm_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = qtm_pkg::REG_MAX_BOOST;
    logic [14:0] cfg_data = '0;

    logic [14:0] boost_lim = 15'd16384;
    logic [14:0] thr_lim = 15'd16384;
    logic diff_thrust = 1'b1;

    qtm_pkg::qtm_out_t mix_queue[$];
    int mismatches = 0;
    int cycles = 0;
    bit hold_off = 1'b0;
    bit rx_enable = 1'b1;
    bit fill_start = 1'b0;

    quad_tilt_motor_mixer dut (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint round_shift(longint x, int sh);
        longint unit;
        longint y;
        unit = longint'(1) << sh;
        y = x + (unit >>> 1);
        if (y >= 0) return y / unit;
        return -((-y + unit - 1) / unit);
    endfunction

    function automatic longint sat(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint pulse_weight(logic [11:0] pulse);
        longint d;
        longint mag;
        d = sat(longint'(pulse), 1000, 2000) - 1500;
        mag = ((d < 0 ? -d : d) * 4096 + 62) / 125;
        return d < 0 ? -mag : mag;
    endfunction

    function automatic qtm_pkg::qtm_out_t mix_motors(qtm_pkg::qtm_in_t a);
        qtm_pkg::qtm_out_t r;
        longint g, roll, pitch, yaw, thr, boost, max_out, min_out;
        longint wp, wy, s, m, tmax, tmin, adj, n, mag, q;
        longint base, rr, pp, yy;
        longint t[4];
        bit lo, hi, rl;
        g = a.comp_gain;
        if (g < 16384) g = 16384;
        roll = round_shift((longint'(a.roll_demand) + longint'(a.roll_feedforward)) * g, 14);
        pitch = longint'(a.pitch_demand) + longint'(a.pitch_feedforward);
        yaw = longint'(a.yaw_demand) + longint'(a.yaw_feedforward);
        thr = round_shift(longint'(a.throttle_demand) * g, 14);
        boost = round_shift(longint'(boost_lim) * g, 14);
        max_out = round_shift(longint'(thr_lim) * g, 14);
        min_out = longint'(a.ext_min_throttle) < boost ? longint'(a.ext_min_throttle) : boost;
        wp = pulse_weight(a.pitch_stick_pulse);
        wy = pulse_weight(a.yaw_stick_pulse);
        s = wp < 0 ? -wp : wp;
        m = 16384 - s;
        lo = 0; hi = 0; rl = 0; adj = 0;
        if (thr <= min_out) begin
            thr = min_out;
            lo = 1;
        end
        if (thr >= max_out) begin
            thr = max_out;
            hi = 1;
        end
        if (roll >= 16384) begin
            roll = 16384;
            rl = 1;
        end
        base = thr * 16384 * 16384;
        rr = roll * 7373 * 16384;
        pp = m * pitch * 6554;
        yy = yaw * 7373 * 16384;
        t[0] = round_shift(base - rr + pp + yy, 28);
        t[1] = round_shift(base + rr - pp + yy, 28);
        t[2] = round_shift(base + rr + pp - yy, 28);
        t[3] = round_shift(base - rr - pp - yy, 28);
        tmax = t[0];
        tmin = t[0];
        for (int i = 1; i < 4; i++) begin
            if (t[i] > tmax) tmax = t[i];
            if (t[i] < tmin) tmin = t[i];
        end
        if (tmax > 16384) begin
            adj = 16384 - tmax;
            hi = 1;
        end else if (tmin < 0) begin
            adj = -tmin;
            if (thr + adj > boost) begin
                adj = boost - thr;
                if (adj < 0) adj = 0;
                rl = 1;
            end
            lo = 1;
        end
        r.thrust_front_a = 15'(sat(t[0] + adj, 0, 16384));
        r.thrust_front_b = 15'(sat(t[1] + adj, 0, 16384));
        r.thrust_rear_a = 15'(sat(t[2] + adj, 0, 16384));
        r.thrust_rear_b = 15'(sat(t[3] + adj, 0, 16384));
        n = diff_thrust ? thr + adj : thr;
        mag = ((n < 0 ? -n : n) * 2 * 16384 + g) / (2 * g);
        q = n < 0 ? -mag : mag;
        r.avg_throttle_out = 16'(sat(q, -32768, 32767));
        r.tilt_pitch_cmd = 16'(sat(round_shift(-wp * 11469 * 16384 - s * pitch * 4915, 28),
                                   -32768, 32767));
        r.tilt_yaw_cmd = 16'(sat(round_shift(wy * 9830, 14), -32768, 32767));
        r.hit_throttle_low = lo;
        r.hit_throttle_high = hi;
        r.hit_roll_limit = rl;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        qtm_pkg::qtm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (mix_queue.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result item %h", m_data);
            end else begin
                want = mix_queue.pop_front();
                if (m_data !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("mismatch exp %h got %h", want, m_data);
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (hold_off || !rx_enable) m_ready <= 1'b0;
        else if (cycles % 97 < 40) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // long receiver hold-off while the sender keeps offering items
    initial begin
        wait (fill_start);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (200) @(negedge aclk);
        hold_off = 1'b0;
    end

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            qtm_pkg::REG_MAX_BOOST: boost_lim = val;
            qtm_pkg::REG_MAX_THR: thr_lim = val;
            qtm_pkg::REG_DIFF_THRUST: diff_thrust = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (mix_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // holds valid across back-to-back items, lowers it only on a gap
    task automatic send_item(qtm_pkg::qtm_in_t d, qtm_pkg::qtm_out_t want);
        s_valid <= 1'b1;
        s_data <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mix_queue.push_back(want);
        @(negedge aclk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    function automatic qtm_pkg::qtm_in_t rand_item(int mode);
        qtm_pkg::qtm_in_t d;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        d = raw[$bits(qtm_pkg::qtm_in_t)-1:0];
        if (mode != 0) begin
            d.roll_demand = 16'($signed($urandom_range(0, 12000)) - 6000);
            d.roll_feedforward = 16'($signed($urandom_range(0, 4000)) - 2000);
            d.pitch_demand = 16'($signed($urandom_range(0, 12000)) - 6000);
            d.pitch_feedforward = 16'($signed($urandom_range(0, 4000)) - 2000);
            d.yaw_demand = 16'($signed($urandom_range(0, 12000)) - 6000);
            d.yaw_feedforward = 16'($signed($urandom_range(0, 4000)) - 2000);
            d.throttle_demand = 15'($urandom_range(0, 16384));
            d.comp_gain = 15'($urandom_range(16384, 32767));
            d.ext_min_throttle = 15'($urandom_range(0, 4000));
            d.pitch_stick_pulse = 12'($urandom_range(800, 2200));
            d.yaw_stick_pulse = 12'($urandom_range(800, 2200));
        end
        return d;
    endfunction

    stim_row_t rows[$];
    stim_row_t row;

    initial begin
        qtm_pkg::qtm_in_t d;
        qtm_pkg::qtm_out_t z;
        int burst;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // neutral sticks, zero demand, default limits: every thrust at zero
        d = '0;
        d.comp_gain = 15'd16384;
        d.pitch_stick_pulse = 12'd1500;
        d.yaw_stick_pulse = 12'd1500;
        z = '0;
        z.hit_throttle_low = 1'b1;
        row.din = d; row.has_exp = 1; row.exp_out = z; rows.push_back(row);
        // full throttle, gain 1.0: all at one, high flag on equality
        d.throttle_demand = 15'd16384;
        z = '0;
        z.thrust_front_a = 15'd16384; z.thrust_front_b = 15'd16384;
        z.thrust_rear_a = 15'd16384; z.thrust_rear_b = 15'd16384;
        z.avg_throttle_out = 16'sd16384; z.hit_throttle_high = 1'b1;
        row.din = d; row.exp_out = z; rows.push_back(row);
        row.has_exp = 0;
        // field extremes, pulse saturation, gain below one, roll clamp
        d = '0; d.roll_demand = 16'sh7fff; d.roll_feedforward = 16'sh7fff;
        d.pitch_stick_pulse = 12'd800; d.yaw_stick_pulse = 12'd2200;
        row.din = d; rows.push_back(row);
        d = '0; d.roll_demand = 16'sh8000; d.roll_feedforward = 16'sh8000;
        d.pitch_demand = 16'sh8000; d.pitch_feedforward = 16'sh8000;
        d.yaw_demand = 16'sh8000; d.yaw_feedforward = 16'sh8000;
        d.throttle_demand = 15'h7fff; d.comp_gain = 15'h7fff; d.ext_min_throttle = 15'h7fff;
        d.pitch_stick_pulse = 12'hfff; d.yaw_stick_pulse = 12'd0;
        row.din = d; rows.push_back(row);
        d.pitch_demand = 16'sh7fff; d.pitch_feedforward = 16'sh7fff;
        d.yaw_demand = 16'sh7fff; d.yaw_feedforward = 16'sh7fff;
        d.pitch_stick_pulse = 12'd1000; d.yaw_stick_pulse = 12'd2000;
        row.din = d; rows.push_back(row);
        d = '0; d.throttle_demand = 15'd8000; d.comp_gain = 15'd20000;
        d.roll_demand = 16'sd9000; d.pitch_demand = -16'sd3000; d.yaw_demand = 16'sd2000;
        d.pitch_stick_pulse = 12'd1700; d.yaw_stick_pulse = 12'd1200;
        row.din = d; rows.push_back(row);
        d.throttle_demand = 15'd500; d.roll_demand = -16'sd9000;
        row.din = d; rows.push_back(row);
        d.throttle_demand = 15'd16000; d.ext_min_throttle = 15'd16384;
        row.din = d; rows.push_back(row);
        d = '0; d.throttle_demand = 15'd100; d.comp_gain = 15'd16383;
        d.yaw_demand = 16'sd12000; d.pitch_stick_pulse = 12'd1501;
        d.yaw_stick_pulse = 12'd1499;
        row.din = d; rows.push_back(row);

        foreach (rows[i]) begin
            z = mix_motors(rows[i].din);
            send_item(rows[i].din, rows[i].has_exp ? rows[i].exp_out : z);
        end
        idle_gap(1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(qtm_pkg::REG_MAX_BOOST, 15'd0);
                    write_reg(qtm_pkg::REG_MAX_THR, 15'd16384);
                    write_reg(qtm_pkg::REG_DIFF_THRUST, 15'd0);
                end
                1: begin
                    write_reg(qtm_pkg::REG_MAX_BOOST, 15'h7fff);
                    write_reg(qtm_pkg::REG_MAX_THR, 15'h7fff);
                    write_reg(qtm_pkg::REG_DIFF_THRUST, 15'd1);
                end
                2: begin
                    write_reg(qtm_pkg::REG_MAX_BOOST, 15'd8000);
                    write_reg(qtm_pkg::REG_MAX_THR, 15'd0);
                end
                3: begin
                    write_reg(2'd3, 15'h7fff);
                    write_reg(qtm_pkg::REG_MAX_BOOST, 15'($urandom_range(0, 32767)));
                    write_reg(qtm_pkg::REG_MAX_THR, 15'($urandom_range(8000, 20000)));
                    write_reg(qtm_pkg::REG_DIFF_THRUST, 15'($urandom_range(0, 1)));
                end
                4: begin
                    write_reg(qtm_pkg::REG_MAX_BOOST, 15'd16384);
                    write_reg(qtm_pkg::REG_MAX_THR, 15'd14000);
                    write_reg(qtm_pkg::REG_DIFF_THRUST, 15'd1);
                end
                default: begin
                    write_reg(qtm_pkg::REG_MAX_BOOST, 15'd12000);
                    write_reg(qtm_pkg::REG_MAX_THR, 15'd16384);
                end
            endcase
            @(negedge aclk);
            if (ph == 2) fill_start = 1'b1;
            for (int i = 0; i < RAND_ITEMS / 6; i++) begin
                d = rand_item($urandom_range(0, 4) != 0);
                send_item(d, mix_motors(d));
                burst = $urandom_range(0, 9);
                if (burst < 3) idle_gap($urandom_range(1, 12));
            end
            idle_gap(1);
            wait_idle();
        end
        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== quad_tilt_motor_mixer.f =====
rtl/core/qtm_pkg.sv
rtl/core/qtm_front.sv
rtl/core/qtm_mix.sv
rtl/core/qtm_div.sv
rtl/core/quad_tilt_motor_mixer.sv
bench/quad_tilt_motor_mixer_tb.sv
